@@ design/plrf_pkg.sv @@
// plrf_pkg: types, register indexes and helpers shared by the position loop block
// no dependencies; used by plrf_csr, plrf_ctrl, plrf_dp and the top level
package plrf_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_RAMP_STEP       = 3'd0;
   localparam logic [2:0] CSR_ERROR_LIMIT     = 3'd1;
   localparam logic [2:0] CSR_POSITION_GAIN   = 3'd2;
   localparam logic [2:0] CSR_FF_MODE         = 3'd3;
   localparam logic [2:0] CSR_FF_SCALE        = 3'd4;
   localparam logic [2:0] CSR_FF_GAIN         = 3'd5;
   localparam logic [2:0] CSR_FILTER_COEFF    = 3'd6;
   localparam logic [2:0] CSR_PULSES_PER_TURN = 3'd7;

   // feedforward mode codes
   localparam logic [1:0] FF_MODE_NONE   = 2'd0;
   localparam logic [1:0] FF_MODE_FILTER = 2'd1;
   localparam logic [1:0] FF_MODE_HOLD   = 2'd2;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   typedef struct packed {
      logic signed [31:0] position_target;
      logic signed [11:0] turn_count;
      logic        [19:0] in_turn_count;
      logic               ramp_enable;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive_value;
      logic signed [31:0] ramped_position;
      logic signed [31:0] clamped_error;
   } rsp_type;

   typedef struct packed {
      logic [20:0] ramp_step;
      logic [30:0] error_limit;
      logic [23:0] position_gain;
      logic [1:0]  ff_mode;
      logic [31:0] ff_scale;
      logic [23:0] ff_gain;
      logic [16:0] filter_coeff;
      logic [20:0] pulses_per_turn;
   } cfg_type;

   // operand pair for the shared multiplier
   typedef enum logic [2:0] {
      MUL_FEEDBACK,
      MUL_DELTA,
      MUL_FILTER,
      MUL_PGAIN,
      MUL_FFGAIN
   } mul_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        ramp_upd;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        fb_upd;
      logic        prev_upd;
      logic        err_upd;
      logic        x_upd;
      logic        filt_upd;
      logic        pterm_upd;
      logic        out_load;
   } dp_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

endpackage

@@ design/position_loop_ramp_p_feedforward_core.sv @@
// position loop core: ramped reference, clamped p term and velocity feedforward
// after the accepting edge the sequencer steps through RAMP, FEEDB, ERR, FILT,
// PTERM, FFMUL and SUM; SUM registers rsp_valid once rsp is free; req_stall
// holds off new words until IDLE, past all five shared multiplier passes
// reset: synchronous; loop state zero, registers at their reset values, rsp empty
// depends on plrf_pkg, plrf_csr, plrf_ctrl, plrf_dp
module position_loop_ramp_p_feedforward_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  plrf_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output plrf_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   plrf_pkg::cfg_type    cfg;
   plrf_pkg::dp_cmd_type cmd;

   plrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   plrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   plrf_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ design/plrf_csr.sv @@
// plrf_csr: configuration register file with reset values
// depends on plrf_pkg
module plrf_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   output plrf_pkg::cfg_type    cfg
);

   plrf_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step       <= 21'd1;
         cfg_ff.error_limit     <= 31'd5000;
         cfg_ff.position_gain   <= 24'd3277;
         cfg_ff.ff_mode         <= plrf_pkg::FF_MODE_NONE;
         cfg_ff.ff_scale        <= 32'd0;
         cfg_ff.ff_gain         <= 24'd0;
         cfg_ff.filter_coeff    <= 17'd65536;
         cfg_ff.pulses_per_turn <= 21'd65536;
      end else if (csr_valid) begin
         unique case (csr_index)
            plrf_pkg::CSR_RAMP_STEP:       cfg_ff.ramp_step       <= csr_data[20:0];
            plrf_pkg::CSR_ERROR_LIMIT:     cfg_ff.error_limit     <= csr_data[30:0];
            plrf_pkg::CSR_POSITION_GAIN:   cfg_ff.position_gain   <= csr_data[23:0];
            plrf_pkg::CSR_FF_MODE:         cfg_ff.ff_mode         <= csr_data[1:0];
            plrf_pkg::CSR_FF_SCALE:        cfg_ff.ff_scale        <= csr_data;
            plrf_pkg::CSR_FF_GAIN:         cfg_ff.ff_gain         <= csr_data[23:0];
            plrf_pkg::CSR_FILTER_COEFF:    cfg_ff.filter_coeff    <= csr_data[16:0];
            plrf_pkg::CSR_PULSES_PER_TURN: cfg_ff.pulses_per_turn <= csr_data[20:0];
            default: ;
         endcase
      end
   end

endmodule

@@ design/plrf_ctrl.sv @@
// plrf_ctrl: sequencer for one control tick, drives datapath commands
// depends on plrf_pkg
module plrf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output plrf_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAMP,
      ST_FEEDB,
      ST_ERR,
      ST_FILT,
      ST_PTERM,
      ST_FFMUL,
      ST_SUM
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = plrf_pkg::MUL_FEEDBACK;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_RAMP;
            end
         end
         ST_RAMP: begin
            cmd.ramp_upd = 1'b1;
            cmd.mul_go   = 1'b1;
            cmd.mul_sel  = plrf_pkg::MUL_FEEDBACK;
            state_in     = ST_FEEDB;
         end
         ST_FEEDB: begin
            cmd.fb_upd   = 1'b1;
            cmd.prev_upd = 1'b1;
            cmd.mul_go   = 1'b1;
            cmd.mul_sel  = plrf_pkg::MUL_DELTA;
            state_in     = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_upd = 1'b1;
            cmd.x_upd   = 1'b1;
            state_in    = ST_FILT;
         end
         ST_FILT: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = plrf_pkg::MUL_FILTER;
            state_in    = ST_PTERM;
         end
         ST_PTERM: begin
            cmd.filt_upd = 1'b1;
            cmd.mul_go   = 1'b1;
            cmd.mul_sel  = plrf_pkg::MUL_PGAIN;
            state_in     = ST_FFMUL;
         end
         ST_FFMUL: begin
            cmd.pterm_upd = 1'b1;
            cmd.mul_go    = 1'b1;
            cmd.mul_sel   = plrf_pkg::MUL_FFGAIN;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            // wait here while the previous word is still unread
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/plrf_dp.sv @@
// plrf_dp: ramp, feedback, error clamp, feedforward filter and drive sum
// around one shared 33x33 signed multiplier; depends on plrf_pkg
module plrf_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  plrf_pkg::dp_cmd_type  cmd,
   input  plrf_pkg::cfg_type     cfg,
   input  plrf_pkg::req_type     req_data,
   output plrf_pkg::rsp_type     rsp_data
);

   plrf_pkg::req_type  req_ff;
   plrf_pkg::rsp_type  rsp_ff, rsp_in;

   // loop state
   logic signed [31:0] ramped_ff, ramped_in;
   logic signed [31:0] prev_ff;
   logic signed [31:0] filt_ff, filt_in;
   logic signed [31:0] ffv_ff;

   // working registers
   logic signed [65:0] prod_ff;
   logic signed [31:0] fb_ff, fb_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] x_ff;
   logic signed [56:0] pterm_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [32:0] ramp_diff, step_s, err_raw, lim_s, lim_neg;
   logic signed [49:0] filt_d;
   logic signed [50:0] filt_sum;
   logic signed [49:0] ff_term;
   logic signed [57:0] drive_sum;

   assign rsp_data = rsp_ff;

   // ramp toward target
   always_comb begin
      ramp_diff = 33'(req_ff.position_target) - 33'(ramped_ff);
      step_s    = $signed({12'd0, cfg.ramp_step});
      if (ramp_diff > step_s) begin
         ramped_in = ramped_ff + $signed({11'd0, cfg.ramp_step});
      end else if (ramp_diff < -step_s) begin
         ramped_in = ramped_ff - $signed({11'd0, cfg.ramp_step});
      end else begin
         ramped_in = req_ff.position_target;
      end
   end

   // multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         plrf_pkg::MUL_FEEDBACK: begin
            mul_a = 33'(req_ff.turn_count);
            mul_b = $signed({12'd0, cfg.pulses_per_turn});
         end
         plrf_pkg::MUL_DELTA: begin
            mul_a = 33'(ramped_ff) - 33'(prev_ff);
            mul_b = $signed({1'b0, cfg.ff_scale});
         end
         plrf_pkg::MUL_FILTER: begin
            mul_a = 33'(x_ff) - 33'(filt_ff);
            mul_b = $signed({16'd0, cfg.filter_coeff});
         end
         plrf_pkg::MUL_PGAIN: begin
            mul_a = 33'(err_ff);
            mul_b = $signed({9'd0, cfg.position_gain});
         end
         plrf_pkg::MUL_FFGAIN: begin
            mul_a = 33'(ffv_ff);
            mul_b = $signed({9'd0, cfg.ff_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // feedback wraps to 32 bits, error is exact before the clamp
   always_comb begin
      fb_in   = $signed(prod_ff[31:0] + {12'd0, req_ff.in_turn_count});
      err_raw = 33'(ramped_ff) - 33'(fb_ff);
      lim_s   = $signed({2'd0, cfg.error_limit});
      lim_neg = -lim_s;
      if (err_raw > lim_s) begin
         err_in = $signed(lim_s[31:0]);
      end else if (err_raw < lim_neg) begin
         err_in = $signed(lim_neg[31:0]);
      end else begin
         err_in = $signed(err_raw[31:0]);
      end
   end

   // low-pass step, shift floors toward minus infinity
   always_comb begin
      filt_d   = $signed(prod_ff[65:16]);
      filt_sum = 51'(filt_ff) + 51'(filt_d);
      filt_in  = plrf_pkg::sat32(66'(filt_sum));
   end

   always_comb begin
      ff_term   = $signed(prod_ff[65:16]);
      drive_sum = 58'(pterm_ff) + 58'(ff_term);
      rsp_in.drive_value     = plrf_pkg::sat32(66'(drive_sum));
      rsp_in.ramped_position = ramped_ff;
      rsp_in.clamped_error   = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramped_ff <= '0;
         prev_ff   <= '0;
         filt_ff   <= '0;
         ffv_ff    <= '0;
      end else begin
         if (cmd.ramp_upd && req_ff.ramp_enable) begin
            ramped_ff <= ramped_in;
         end
         if (cmd.prev_upd) begin
            prev_ff <= ramped_ff;
         end
         if (cmd.filt_upd) begin
            case (cfg.ff_mode)
               plrf_pkg::FF_MODE_FILTER: begin
                  filt_ff <= filt_in;
                  ffv_ff  <= filt_in;
               end
               plrf_pkg::FF_MODE_HOLD: ;
               default: ffv_ff <= '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         req_ff <= req_data;
      end
      if (cmd.mul_go) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.fb_upd) begin
         fb_ff <= fb_in;
      end
      if (cmd.err_upd) begin
         err_ff <= err_in;
      end
      if (cmd.x_upd) begin
         x_ff <= plrf_pkg::sat32(prod_ff);
      end
      if (cmd.pterm_upd) begin
         pterm_ff <= $signed(prod_ff[56:0]);
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ test/tb.sv @@
// tb: self-checking bench for the position loop core, with its own shadow of one servo tick
// drives words over the req/rsp stall handshakes and settings over the csr write port
// depends on plrf_pkg and position_loop_ramp_p_feedforward_core
`timescale 1ns / 100ps

module tb;

   localparam int         LONG_HOLD     = 300;
   localparam logic [1:0] FF_MODE_SPARE = 2'd3;

   typedef struct {
      bit                 is_csr;
      logic [2:0]         index;
      logic [31:0]        value;
      plrf_pkg::req_type  word;
      bit                 pinned;
      plrf_pkg::rsp_type  result;
   } step_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   plrf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   plrf_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_data = '0;

   // typed-in result travelling with the word on offer
   bit                word_pinned = 1'b0;
   plrf_pkg::rsp_type word_pin_rsp = '0;

   bit                no_gaps = 1'b0;
   int                hold_asks = 0;
   int                mismatches = 0;
   plrf_pkg::rsp_type due_words[$];
   step_row_type      plan[$];

   // shadow of the loop state and the settings
   logic signed [31:0] ref_pos = '0;
   logic signed [31:0] prev_pos = '0;
   logic signed [31:0] filt_state = '0;
   logic signed [31:0] ff_state = '0;
   plrf_pkg::cfg_type shadow = '{ramp_step: 21'd1, error_limit: 31'd5000,
                                 position_gain: 24'd3277,
                                 ff_mode: plrf_pkg::FF_MODE_NONE, ff_scale: 32'd0,
                                 ff_gain: 24'd0, filter_coeff: 17'd65536,
                                 pulses_per_turn: 21'd65536};

   // largest legal value and width of each setting, in register index order
   int unsigned reg_top [8] = '{1048576, 2147483647, 16777215, 2, 32'hFFFFFFFF,
                                16777215, 65536, 1048576};
   int          reg_bits [8] = '{21, 31, 24, 2, 32, 24, 17, 21};

   position_loop_ramp_p_feedforward_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [31:0] clip_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction

   // one control tick: advances the shadow state and returns the outgoing word
   function automatic plrf_pkg::rsp_type servo_tick(input plrf_pkg::req_type w);
      longint            stride, lim, diff, fb_wide, err, delta, x, y, drv;
      longint unsigned   adelta, scale, mag;
      plrf_pkg::rsp_type r;
      stride = longint'(shadow.ramp_step);
      lim    = longint'(shadow.error_limit);
      if (w.ramp_enable) begin
         diff = longint'(w.position_target) - longint'(ref_pos);
         if (diff > stride) ref_pos = ref_pos + 32'(stride);
         else if (diff < -stride) ref_pos = ref_pos - 32'(stride);
         else ref_pos = w.position_target;
      end
      // feedback wraps at 32 bits, the error itself does not
      fb_wide = longint'(w.turn_count) * longint'(shadow.pulses_per_turn)
              + longint'(w.in_turn_count);
      err = longint'(ref_pos) - longint'($signed(fb_wide[31:0]));
      if (err > lim) err = lim;
      if (err < -lim) err = -lim;
      case (shadow.ff_mode)
         plrf_pkg::FF_MODE_FILTER: begin
            delta  = longint'(ref_pos) - longint'(prev_pos);
            adelta = (delta < 0) ? -delta : delta;
            scale  = 64'(shadow.ff_scale);
            mag    = adelta * scale;
            if (delta >= 0) begin
               if (mag > 64'd2147483647) x = 64'sd2147483647;
               else x = longint'(mag);
            end else if (mag > 64'd2147483648) begin
               x = -64'sd2147483648;
            end else begin
               x = -longint'(mag);
            end
            y = longint'(filt_state);
            filt_state = clip_word(y + (((x - y) * longint'(shadow.filter_coeff)) >>> 16));
            ff_state = filt_state;
         end
         plrf_pkg::FF_MODE_HOLD: ; // filter and feedforward keep their values
         default: ff_state = '0;
      endcase
      prev_pos = ref_pos;
      drv = err * longint'(shadow.position_gain)
          + ((longint'(ff_state) * longint'(shadow.ff_gain)) >>> 16);
      r.drive_value     = clip_word(drv);
      r.ramped_position = ref_pos;
      r.clamped_error   = 32'(err);
      return r;
   endfunction

   function automatic step_row_type csr_row(input logic [2:0] idx, input logic [31:0] val);
      step_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.index  = idx;
      row.value  = val;
      return row;
   endfunction

   function automatic step_row_type word_row(input logic signed [31:0] t, input int n,
                                             input int w, input bit en);
      step_row_type row;
      row = '{default: '0};
      row.word.position_target = t;
      row.word.turn_count      = 12'(n);
      row.word.in_turn_count   = 20'(w);
      row.word.ramp_enable     = en;
      return row;
   endfunction

   function automatic step_row_type pin_row(input logic signed [31:0] t, input int n,
                                            input int w, input bit en,
                                            input int d, input int p, input int e);
      step_row_type row;
      row = word_row(t, n, w, en);
      row.pinned = 1'b1;
      row.result.drive_value     = d;
      row.result.ramped_position = p;
      row.result.clamped_error   = e;
      return row;
   endfunction

   task automatic write_setting(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_word(input plrf_pkg::req_type w, input bit pin,
                            input plrf_pkg::rsp_type pinned_rsp);
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_data     <= w;
      word_pinned  <= pin;
      word_pin_rsp <= pinned_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      plrf_pkg::rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               plrf_pkg::CSR_RAMP_STEP:       shadow.ramp_step       = csr_data[20:0];
               plrf_pkg::CSR_ERROR_LIMIT:     shadow.error_limit     = csr_data[30:0];
               plrf_pkg::CSR_POSITION_GAIN:   shadow.position_gain   = csr_data[23:0];
               plrf_pkg::CSR_FF_MODE:         shadow.ff_mode         = csr_data[1:0];
               plrf_pkg::CSR_FF_SCALE:        shadow.ff_scale        = csr_data;
               plrf_pkg::CSR_FF_GAIN:         shadow.ff_gain         = csr_data[23:0];
               plrf_pkg::CSR_FILTER_COEFF:    shadow.filter_coeff    = csr_data[16:0];
               plrf_pkg::CSR_PULSES_PER_TURN: shadow.pulses_per_turn = csr_data[20:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = servo_tick(req_data);
            if (word_pinned) want = word_pin_rsp;
            due_words.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               mismatches++;
               $display("%0t: expected no word, got drive %0d pos %0d err %0d", $time,
                        rsp_data.drive_value, rsp_data.ramped_position,
                        rsp_data.clamped_error);
            end else begin
               want = due_words.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  $display("%0t: expected drive %0d pos %0d err %0d, got %0d %0d %0d",
                           $time, want.drive_value, want.ramped_position,
                           want.clamped_error, rsp_data.drive_value,
                           rsp_data.ramped_position, rsp_data.clamped_error);
               end
            end
         end
      end
   end

   // receiver pacing: random stall bursts, plus one long hold-off when asked
   initial begin : rsp_pacing
      int served;
      served = 0;
      forever begin
         @(negedge clock);
         if (served != hold_asks) begin
            served = hold_asks;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(0, 18)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      plrf_pkg::req_type w;
      logic [31:0]       v, mask;
      int                phase, k, noise;
      w = '0;

      // straight after reset: ramp of one count, limit 5000, gain 3277, no feedforward
      plan.push_back(pin_row(0, 0, 0, 1'b0, 0, 0, 0));
      plan.push_back(pin_row(100, 0, 0, 1'b1, 3277, 1, 1));
      plan.push_back(pin_row(32'h80000000, 0, 0, 1'b1, 0, 0, 0));
      plan.push_back(pin_row(32'h7FFFFFFF, -2048, 0, 1'b0, 16385000, 0, 5000));
      plan.push_back(pin_row(0, 2047, 1048575, 1'b0, -16385000, 0, -5000));
      plan.push_back(pin_row(32'h7FFFFFFF, 0, 1, 1'b1, 0, 1, 0));
      // zero pulses per turn: feedback is the in-turn count alone
      plan.push_back(csr_row(plrf_pkg::CSR_PULSES_PER_TURN, 0));
      plan.push_back(word_row(32'h7FFFFFFF, -1, 1048575, 1'b1));
      // widest ramp and limit with full gain, drive saturates both ways
      plan.push_back(csr_row(plrf_pkg::CSR_RAMP_STEP, 1048576));
      plan.push_back(csr_row(plrf_pkg::CSR_ERROR_LIMIT, 32'h7FFFFFFF));
      plan.push_back(csr_row(plrf_pkg::CSR_POSITION_GAIN, 32'hFFFFFF));
      plan.push_back(word_row(32'h7FFFFFFF, 2047, 0, 1'b1));
      plan.push_back(word_row(32'h80000000, 0, 1048575, 1'b1));
      // filtered feedforward at full scale and gain, p term off
      plan.push_back(csr_row(plrf_pkg::CSR_FF_MODE, 32'(plrf_pkg::FF_MODE_FILTER)));
      plan.push_back(csr_row(plrf_pkg::CSR_FF_SCALE, 32'hFFFFFFFF));
      plan.push_back(csr_row(plrf_pkg::CSR_FF_GAIN, 32'hFFFFFF));
      plan.push_back(csr_row(plrf_pkg::CSR_FILTER_COEFF, 65536));
      plan.push_back(csr_row(plrf_pkg::CSR_POSITION_GAIN, 0));
      plan.push_back(word_row(0, 0, 0, 1'b1));
      plan.push_back(word_row(32'h7FFFFFFF, 0, 0, 1'b1));
      // coefficient above one makes the filter overshoot
      plan.push_back(csr_row(plrf_pkg::CSR_FILTER_COEFF, 32'h0001FFFF));
      plan.push_back(word_row(32'h80000000, 0, 0, 1'b1));
      plan.push_back(word_row(32'h7FFFFFFF, 0, 0, 1'b1));
      plan.push_back(csr_row(plrf_pkg::CSR_FF_MODE, 32'(plrf_pkg::FF_MODE_HOLD)));
      plan.push_back(word_row(0, 5, 3, 1'b1));
      // spare mode code behaves as no feedforward
      plan.push_back(csr_row(plrf_pkg::CSR_FF_MODE, 32'(FF_MODE_SPARE)));
      plan.push_back(word_row(1000, 0, 0, 1'b1));
      // zero ramp freezes the reference, zero limit zeroes the error
      plan.push_back(csr_row(plrf_pkg::CSR_FF_MODE, 32'(plrf_pkg::FF_MODE_NONE)));
      plan.push_back(csr_row(plrf_pkg::CSR_RAMP_STEP, 0));
      plan.push_back(csr_row(plrf_pkg::CSR_ERROR_LIMIT, 0));
      plan.push_back(csr_row(plrf_pkg::CSR_POSITION_GAIN, 3277));
      plan.push_back(word_row(12345, -3, 77, 1'b1));

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (due_words.size() != 0);
            write_setting(plan[i].index, plan[i].value);
         end else begin
            csr_valid <= 1'b0;
            send_word(plan[i].word, plan[i].pinned, plan[i].result);
         end
      end

      for (phase = 0; phase < 10; phase++) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (due_words.size() != 0);
         no_gaps = (phase == 9);
         for (k = 0; k < 8; k++) begin
            mask = 32'((64'd1 << reg_bits[k]) - 64'd1);
            case ($urandom_range(0, 7))
               0: v = '0;
               1: v = reg_top[k];
               2: v = mask;
               default: v = $urandom_range(0, reg_top[k]) >> $urandom_range(0, reg_bits[k] - 1);
            endcase
            if (3'(k) == plrf_pkg::CSR_FF_MODE && phase > 2 && phase % 2 == 1)
               v = 32'(plrf_pkg::FF_MODE_FILTER);
            if (phase == 1) v = mask;
            else if (phase == 2) v = '0;
            write_setting(3'(k), v);
         end
         csr_valid <= 1'b0;
         // back up the block behind a long receiver hold-off
         if (phase == 3) hold_asks++;

         for (k = 0; k < 110; k++) begin
            // sender waits once mid-phase until every outstanding word has come back
            if (phase == 5 && k == 55) begin
               req_valid <= 1'b0;
               do @(negedge clock); while (due_words.size() != 0);
            end
            case ($urandom_range(0, 9))
               0, 1: begin
                  w.position_target = $urandom;
                  w.turn_count      = 12'($urandom);
                  w.in_turn_count   = 20'($urandom);
                  w.ramp_enable     = 1'($urandom);
               end
               2, 3, 4, 5, 6: begin
                  // feedback follows the reference closely, error mostly inside the limit
                  if ($urandom_range(0, 7) == 0) w.position_target = $urandom_range(0, 1048575);
                  noise = int'($urandom_range(0, 2000)) - 1000;
                  w.turn_count    = '0;
                  w.in_turn_count = 20'(ref_pos + noise);
                  w.ramp_enable   = ($urandom_range(0, 3) != 0);
               end
               default: begin
                  w.position_target = ref_pos + ($signed($urandom) >>> $urandom_range(0, 31));
                  w.turn_count      = 12'(int'($urandom_range(0, 6)) - 3);
                  w.in_turn_count   = 20'($urandom);
                  w.ramp_enable     = ($urandom_range(0, 3) != 0);
               end
            endcase
            send_word(w, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (due_words.size() != 0);
      repeat (24) @(negedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
design/plrf_pkg.sv
design/plrf_csr.sv
design/plrf_ctrl.sv
design/plrf_dp.sv
design/position_loop_ramp_p_feedforward_core.sv
test/tb.sv
